// ===== sv/triangle_tangent_from_uv_unit_macros.svh =====
// assertion helpers for the tangent unit checker
`ifndef TRIANGLE_TANGENT_FROM_UV_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_FROM_UV_UNIT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tangent unit check failed");

// next-cycle implication checked outside reset
`define TTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tangent unit check failed");

`endif

// ===== sv/ttu_pkg.sv =====
`default_nettype none
package ttu_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned DIFF_W = 33;
    localparam int unsigned PROD_W = 66;
    localparam int unsigned SUM_W  = 67;
    localparam logic [31:0] THRESH_RESET = 32'd4295;

    // corner position in a triangle
    localparam logic [1:0] CORNER_ZERO = 2'd0;
    localparam logic [1:0] CORNER_ONE  = 2'd1;
    localparam logic [1:0] CORNER_TWO  = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               first_corner;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               degenerate;
    } tangent_t;

    // one whole triangle handed from front to back
    typedef struct packed {
        logic signed [31:0] p0x;
        logic signed [31:0] p0y;
        logic signed [31:0] p0z;
        logic signed [31:0] p0u;
        logic signed [31:0] p0v;
        logic signed [31:0] p1x;
        logic signed [31:0] p1y;
        logic signed [31:0] p1z;
        logic signed [31:0] p1u;
        logic signed [31:0] p1v;
        logic signed [31:0] p2x;
        logic signed [31:0] p2y;
        logic signed [31:0] p2z;
        logic signed [31:0] p2u;
        logic signed [31:0] p2v;
    } tri_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_ctl_t;

endpackage
`default_nettype wire

// ===== sv/ttu_if.sv =====
`default_nettype none
interface vertex_if;
    logic              valid;
    logic              ready;
    ttu_pkg::vertex_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tangent_if;
    logic              valid;
    logic              ready;
    ttu_pkg::tangent_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface thresh_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ttu_front.sv =====
`default_nettype none
module ttu_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ttu_pkg::vertex_t in_data,
    input  wire logic             q_full,
    output ttu_pkg::queue_ctl_t   ctl,
    output ttu_pkg::tri_t         tri_out
);
    logic [1:0]       count_reg, count_next, cur;
    ttu_pkg::vertex_t c0_reg, c1_reg;
    logic             take;

    assign cur = in_data.first_corner ? ttu_pkg::CORNER_ZERO : count_reg;
    // third corners need queue room, others never stall
    assign in_ready = !(cur == ttu_pkg::CORNER_TWO && q_full);
    assign take = in_valid && in_ready;
    assign ctl.push = take && cur == ttu_pkg::CORNER_TWO;
    assign ctl.full = q_full;

    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            unique case (cur)
                ttu_pkg::CORNER_ZERO: count_next = ttu_pkg::CORNER_ONE;
                ttu_pkg::CORNER_ONE:  count_next = ttu_pkg::CORNER_TWO;
                default:              count_next = ttu_pkg::CORNER_ZERO;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= ttu_pkg::CORNER_ZERO;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && cur == ttu_pkg::CORNER_ZERO)
            c0_reg <= in_data;
        if (take && cur == ttu_pkg::CORNER_ONE)
            c1_reg <= in_data;
    end

    assign tri_out = '{c0_reg.pos_x, c0_reg.pos_y, c0_reg.pos_z, c0_reg.tex_u, c0_reg.tex_v,
                       c1_reg.pos_x, c1_reg.pos_y, c1_reg.pos_z, c1_reg.tex_u, c1_reg.tex_v,
                       in_data.pos_x, in_data.pos_y, in_data.pos_z, in_data.tex_u,
                       in_data.tex_v};
endmodule
`default_nettype wire

// ===== sv/ttu_queue.sv =====
`default_nettype none
module ttu_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire ttu_pkg::tri_t  push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output ttu_pkg::tri_t       pop_data
);
    ttu_pkg::tri_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end
endmodule
`default_nettype wire

// ===== sv/ttu_back.sv =====
`default_nettype none
module ttu_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    threshold,
    input  wire logic           q_valid,
    output logic                q_pop,
    input  wire ttu_pkg::tri_t  tri_in,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ttu_pkg::tangent_t   out_data
);
    localparam int unsigned NUM_W = ttu_pkg::SUM_W + FRAC_BITS;
    localparam int unsigned QBITS = NUM_W;
    localparam int unsigned CNT_W = $clog2(QBITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DET  = 3'd3;
    localparam logic [2:0] ST_NUM  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg;
    logic [1:0] comp_reg;
    logic [1:0] mstep_reg;
    ttu_pkg::tri_t t_reg;

    logic signed [32:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [32:0] e1_reg, e2_reg;
    logic signed [65:0] pa_reg, pb_reg;
    logic [66:0]        detm_reg;
    logic               negdet_reg, negnum_reg;
    logic [NUM_W-1:0]   numm_reg;
    logic [NUM_W:0]     rem_reg;
    logic [32:0]        q_reg;
    logic               sat_reg;
    logic [CNT_W-1:0]   bit_reg;
    logic signed [31:0] res_reg [3];
    logic               deg_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [66:0] diff;
    logic [66:0]        diffm;
    logic [NUM_W:0]     rem_sh;
    logic [NUM_W:0]     rem_sub;
    logic               qb;
    logic [33:0]        q_sh;

    // one shared multiplier: two products for the determinant, two per tangent component
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin ma = du1_reg; mb = dv2_reg; end
            2'd1:    begin ma = du2_reg; mb = dv1_reg; end
            2'd2:    begin ma = e1_reg;  mb = dv2_reg; end
            default: begin ma = e2_reg;  mb = dv1_reg; end
        endcase
    end
    assign prod  = ma * mb;
    assign diff  = 67'(pa_reg) - 67'(pb_reg);
    assign diffm = diff[66] ? 67'(-diff) : 67'(diff);

    assign rem_sh  = {rem_reg[NUM_W-1:0], numm_reg[NUM_W-1]};
    assign qb      = rem_sh >= (NUM_W+1)'(detm_reg);
    assign rem_sub = qb ? rem_sh - (NUM_W+1)'(detm_reg) : rem_sh;
    assign q_sh    = {q_reg, qb};

    assign q_pop = state_reg == ST_IDLE && q_valid;
    assign out_valid = state_reg == ST_OUT;
    assign out_data = '{res_reg[0], res_reg[1], res_reg[2], deg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= 2'd0;
            mstep_reg <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: if (q_valid) state_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    state_reg <= ST_MUL;
                    mstep_reg <= 2'd0;
                end
                ST_MUL:
                begin
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd1)
                        state_reg <= ST_DET;
                end
                ST_DET:
                begin
                    comp_reg <= 2'd0;
                    if (diff == '0 || (diffm[66:32] == '0 && diffm[31:0] < threshold))
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_NUM;
                end
                ST_NUM:
                begin
                    // steps 2 and 3 form the products, step 0 takes their difference
                    if (mstep_reg == 2'd0)
                        state_reg <= ST_DIV;
                    mstep_reg <= mstep_reg + 2'd1;
                end
                ST_DIV:
                    if (bit_reg == CNT_W'(1))
                        state_reg <= ST_FIN;
                ST_FIN:
                begin
                    mstep_reg <= 2'd2;
                    if (comp_reg == 2'd2)
                        state_reg <= ST_OUT;
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_NUM;
                    end
                end
                default:
                    if (out_ready) state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            t_reg <= tri_in;
        if (state_reg == ST_DIFF)
        begin
            du1_reg <= 33'(t_reg.p1u) - 33'(t_reg.p0u);
            dv1_reg <= 33'(t_reg.p1v) - 33'(t_reg.p0v);
            du2_reg <= 33'(t_reg.p2u) - 33'(t_reg.p0u);
            dv2_reg <= 33'(t_reg.p2v) - 33'(t_reg.p0v);
            e1_reg  <= 33'(signed'(t_reg.p1x)) - 33'(signed'(t_reg.p0x));
            e2_reg  <= 33'(signed'(t_reg.p2x)) - 33'(signed'(t_reg.p0x));
        end
        if (state_reg == ST_FIN)
        begin
            e1_reg <= 33'(signed'(comp_reg == 2'd0 ? t_reg.p1y : t_reg.p1z))
                    - 33'(signed'(comp_reg == 2'd0 ? t_reg.p0y : t_reg.p0z));
            e2_reg <= 33'(signed'(comp_reg == 2'd0 ? t_reg.p2y : t_reg.p2z))
                    - 33'(signed'(comp_reg == 2'd0 ? t_reg.p0y : t_reg.p0z));
        end
        if ((state_reg == ST_MUL || state_reg == ST_NUM) && mstep_reg[0] == 1'b0)
            pa_reg <= prod;
        if ((state_reg == ST_MUL || state_reg == ST_NUM) && mstep_reg[0] == 1'b1)
            pb_reg <= prod;
        if (state_reg == ST_DET)
        begin
            detm_reg   <= diffm;
            negdet_reg <= diff[66];
            deg_reg    <= diff == '0 || (diffm[66:32] == '0 && diffm[31:0] < threshold);
            res_reg[0] <= 32'(1) <<< FRAC_BITS;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        if (state_reg == ST_NUM && mstep_reg == 2'd0)
        begin
            negnum_reg <= diff[66];
            numm_reg   <= NUM_W'(diffm) << FRAC_BITS;
            rem_reg    <= '0;
            q_reg      <= '0;
            sat_reg    <= 1'b0;
            bit_reg    <= CNT_W'(QBITS);
        end
        // restoring division, one quotient bit per cycle
        if (state_reg == ST_DIV)
        begin
            rem_reg  <= rem_sub;
            numm_reg <= numm_reg << 1;
            bit_reg  <= bit_reg - CNT_W'(1);
            if (!sat_reg)
            begin
                if (q_sh > 34'h100000000)
                    sat_reg <= 1'b1;
                else
                    q_reg <= q_sh[32:0];
            end
        end
        if (state_reg == ST_FIN)
        begin
            if (negnum_reg != negdet_reg)
                res_reg[comp_reg] <= (sat_reg || q_reg > 33'h080000000)
                    ? 32'sh80000000 : 32'(-q_reg);
            else
                res_reg[comp_reg] <= (sat_reg || q_reg > 33'h07FFFFFFF)
                    ? 32'sh7FFFFFFF : q_reg[31:0];
        end
    end
endmodule
`default_nettype wire

// ===== sv/triangle_tangent_from_uv_unit.sv =====
// corners 0 and 1 give no result; the back skips division for degenerate triangles
// throughput: one vertex per cycle into the front, stalled only when a third corner
// finds the queue full; one triangle at a time in the back, set by the bit-serial
// divider; a two-entry queue lets the front run ahead
// reset: asynchronous active low, clears corner count, queue and back state;
// threshold returns to 4295
`default_nettype none
module triangle_tangent_from_uv_unit #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vertex_if.sink    vertex,
    tangent_if.source tangent,
    thresh_if.sink    cfg
);
    logic [31:0]         thresh_reg;
    ttu_pkg::queue_ctl_t ctl;
    ttu_pkg::tri_t       tri_push, tri_pop;
    logic                q_full, q_ne, q_pop;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= ttu_pkg::THRESH_RESET;
        else if (cfg.valid)
            thresh_reg <= cfg.data;
    end

    ttu_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(vertex.valid), .in_ready(vertex.ready),
        .in_data(vertex.data), .q_full(q_full), .ctl(ctl), .tri_out(tri_push)
    );

    ttu_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(ctl.push), .push_data(tri_push), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_data(tri_pop)
    );

    ttu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .threshold(thresh_reg), .q_valid(q_ne), .q_pop(q_pop),
        .tri_in(tri_pop), .out_valid(tangent.valid), .out_ready(tangent.ready),
        .out_data(tangent.data)
    );

    logic unused;
    assign unused = ctl.full;
endmodule
`default_nettype wire

// ===== sv/ttu_checker.sv =====
`default_nettype none
`include "triangle_tangent_from_uv_unit_macros.svh"
module ttu_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire ttu_pkg::tangent_t out_data,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              in_first
);
    `TTU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `TTU_ASSERT_IMP(a_deg_default, clk, rst_n, out_valid && out_data.degenerate,
        out_data.tangent_y == 32'sd0 && out_data.tangent_z == 32'sd0)
    `TTU_ASSERT_IMP(a_first_ready, clk, rst_n, in_valid && in_first, in_ready)
endmodule

bind triangle_tangent_from_uv_unit ttu_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(tangent.valid), .out_ready(tangent.ready),
    .out_data(tangent.data), .in_valid(vertex.valid), .in_ready(vertex.ready),
    .in_first(vertex.data.first_corner)
);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 320;
    localparam int STALL_LIMIT = 20000;

    class tangent_scoreboard;
        ttu_pkg::tangent_t pending[$];
        ttu_pkg::vertex_t corner0;
        ttu_pkg::vertex_t corner1;
        int corners_held;
        logic [31:0] threshold;
        int errors;

        function new();
            corners_held = 0;
            threshold = ttu_pkg::THRESH_RESET;
            errors = 0;
            corner0 = '0;
            corner1 = '0;
        endfunction

        function logic [31:0] component(logic signed [127:0] num, logic signed [127:0] det);
            logic [127:0] num_mag;
            logic [127:0] det_mag;
            logic [127:0] quot;
            logic flip;
            flip = (num < 0) != (det < 0);
            num_mag = (num < 0) ? -num : num;
            det_mag = (det < 0) ? -det : det;
            quot = (num_mag << FRAC) / det_mag;
            if (flip)
            begin
                if (quot > 128'h8000_0000)
                    quot = 128'h8000_0000;
                return -quot[31:0];
            end
            if (quot > 128'h7FFF_FFFF)
                quot = 128'h7FFF_FFFF;
            return quot[31:0];
        endfunction

        // accepted vertex: update corner state, maybe queue a tangent
        function void note_vertex(ttu_pkg::vertex_t v);
            logic signed [127:0] du1, dv1, du2, dv2, det, det_mag;
            logic signed [127:0] e1 [3];
            logic signed [127:0] e2 [3];
            logic [31:0] res [3];
            ttu_pkg::tangent_t t;
            if (v.first_corner)
                corners_held = 0;
            if (corners_held == 0)
            begin
                corner0 = v;
                corners_held = 1;
                return;
            end
            if (corners_held == 1)
            begin
                corner1 = v;
                corners_held = 2;
                return;
            end
            corners_held = 0;
            du1 = $signed(corner1.tex_u) - $signed(corner0.tex_u);
            dv1 = $signed(corner1.tex_v) - $signed(corner0.tex_v);
            du2 = $signed(v.tex_u) - $signed(corner0.tex_u);
            dv2 = $signed(v.tex_v) - $signed(corner0.tex_v);
            det = du1 * dv2 - du2 * dv1;
            det_mag = (det < 0) ? -det : det;
            if (det_mag == 0 || det_mag < $signed({96'd0, threshold}))
            begin
                t.tangent_x = 32'sd1 <<< FRAC;
                t.tangent_y = '0;
                t.tangent_z = '0;
                t.degenerate = 1'b1;
                pending = {pending, t};
                return;
            end
            e1[0] = $signed(corner1.pos_x) - $signed(corner0.pos_x);
            e1[1] = $signed(corner1.pos_y) - $signed(corner0.pos_y);
            e1[2] = $signed(corner1.pos_z) - $signed(corner0.pos_z);
            e2[0] = $signed(v.pos_x) - $signed(corner0.pos_x);
            e2[1] = $signed(v.pos_y) - $signed(corner0.pos_y);
            e2[2] = $signed(v.pos_z) - $signed(corner0.pos_z);
            for (int i = 0; i < 3; i++)
                res[i] = component(e1[i] * dv2 - e2[i] * dv1, det);
            t.tangent_x = res[0];
            t.tangent_y = res[1];
            t.tangent_z = res[2];
            t.degenerate = 1'b0;
            pending = {pending, t};
        endfunction

        function void check_tangent(ttu_pkg::tangent_t got);
            ttu_pkg::tangent_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected tangent %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tangent_x !== want.tangent_x)
                $display("%0t: tangent_x expected %h actual %h", $time, want.tangent_x,
                         got.tangent_x);
            if (got.tangent_y !== want.tangent_y)
                $display("%0t: tangent_y expected %h actual %h", $time, want.tangent_y,
                         got.tangent_y);
            if (got.tangent_z !== want.tangent_z)
                $display("%0t: tangent_z expected %h actual %h", $time, want.tangent_z,
                         got.tangent_z);
            if (got.degenerate !== want.degenerate)
                $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                         got.degenerate);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    vertex_if vtx ();
    tangent_if tan_ch ();
    thresh_if cfg_ch ();

    tangent_scoreboard sb;
    int rx_hold;
    int idle_cycles = 0;

    triangle_tangent_from_uv_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .vertex(vtx),
        .tangent(tan_ch),
        .cfg(cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver readiness, with forced hold-off stretches
    initial
    begin
        tan_ch.ready = 1'b0;
        rx_hold = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                tan_ch.ready <= 1'b0;
            end
            else
                tan_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tan_ch.valid && tan_ch.ready)
            sb.check_tangent(tan_ch.data);
    end

    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (tan_ch.valid && tan_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_vertex(ttu_pkg::vertex_t v, bit allow_gap = 1'b1);
        int gap;
        vtx.valid <= 1'b1;
        vtx.data <= v;
        do
            @(posedge clk);
        while (!vtx.ready);
        sb.note_vertex(v);
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_corner(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] u, logic [31:0] v, logic first);
        ttu_pkg::vertex_t c;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.tex_u = u;
        c.tex_v = v;
        c.first_corner = first;
        send_vertex(c);
    endtask

    task automatic wait_drained();
        vtx.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.threshold = value;
        cfg_ch.valid <= 1'b0;
    endtask

    function logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 8191)) - 4096;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                          : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function ttu_pkg::vertex_t rand_vertex(logic first);
        ttu_pkg::vertex_t c;
        int pm;
        int tm;
        pm = $urandom_range(0, 3);
        tm = $urandom_range(0, 3);
        c.pos_x = rand_word(pm);
        c.pos_y = rand_word(pm);
        c.pos_z = rand_word(pm);
        c.tex_u = rand_word(tm);
        c.tex_v = rand_word(tm);
        c.first_corner = first;
        return c;
    endfunction

    task automatic random_items(int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                send_vertex(rand_vertex(1'b1));
                send_vertex(rand_vertex(1'b0));
                send_vertex(rand_vertex(1'b0));
                sent += 3;
            end
            else
            begin
                // noise: stray marks and broken triangles
                send_vertex(rand_vertex(1'($urandom_range(0, 1))));
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [31:0] phase_thresh [4];
        sb = new();
        rst_n = 1'b0;
        vtx.valid = 1'b0;
        vtx.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero triangle: zero determinant
        send_corner(0, 0, 0, 0, 0, 1'b1);
        send_corner(0, 0, 0, 0, 0, 1'b0);
        send_corner(0, 0, 0, 0, 0, 1'b0);
        // ordinary unit triangle
        send_corner(0, 0, 0, 0, 0, 1'b1);
        send_corner(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 1'b0);
        send_corner(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
        // resync mid-triangle: third vertex restarts
        send_corner(5, 6, 7, 8, 9, 1'b1);
        send_corner(1, 2, 3, 4, 5, 1'b0);
        send_corner(32'h1234, 0, 0, 0, 0, 1'b1);
        // missing first mark after a finished triangle
        send_corner(32'h0002_0000, 0, 0, 0, 0, 1'b0);
        send_corner(0, 32'h0003_0000, 0, 32'h0004_0000, 0, 1'b0);
        send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 1'b0);

        write_threshold(32'd0);
        // tiny determinant with extreme edges: saturates both ways
        send_corner(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b1);
        send_corner(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0, 1'b0);
        send_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1'b0);
        // extreme texture coordinates
        send_corner(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_corner(0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_corner(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);

        // receiver holds off while the sender keeps offering
        rx_hold = 2000;
        random_items(30);

        phase_thresh[0] = 32'hFFFF_FFFF;
        phase_thresh[1] = $urandom();
        phase_thresh[2] = 32'd0;
        phase_thresh[3] = $urandom_range(1, 100000);
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(phase_thresh[p]);
            random_items(120);
        end

        wait_drained();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
